// ===== src/mlptw_pkg.sv =====
// shared types and constants for the radix page table walker
// no dependencies
package mlptw_pkg;

  localparam int ENTRY_SIZE_BITS = 3;
  localparam int CMD_W = 2;
  localparam int VADDR_W = 30;
  localparam int STATUS_W = 3;
  localparam int PADDR_W = 18;

  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEALLOCATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MAPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OFFSET = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_READ_WAIT,
    S_DECIDE,
    S_CHECK,
    S_SCAN,
    S_CLEAR,
    S_LINK,
    S_FREE,
    S_RESP
  } walk_state_t;

endpackage

// ===== src/multi_level_page_table_walker.sv =====
// radix page table walker with an internal page pool and lowest-free allocator
// depends on mlptw_pkg
//
// One request at a time. The table pool is a single-port-write, registered-read
// memory of POOL_PAGES pages. A translate does a memory read (S_READ) and a
// wait (S_READ_WAIT) for each level it reaches. An allocate adds, per new page,
// a bitmap scan, a clear of each of its 2^(OFFSET_BITS-3) entries and a link,
// bounded by the single write port. A deallocate walks like a translate, then
// frees a mapped page (S_FREE). No clearing pass after reset.
module multi_level_page_table_walker #(
  parameter int OFFSET_BITS = 12,
  parameter int LEVEL_COUNT = 2,
  parameter int POOL_PAGES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // command[1:0], virtual_address[31:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status[2:0], physical_address[20:3], zero
);

  localparam int IDX_W = OFFSET_BITS - mlptw_pkg::ENTRY_SIZE_BITS;
  localparam int PAGE_W = $clog2(POOL_PAGES);
  localparam int ENTRY_W = PAGE_W + 1;
  localparam int ADDR_W = PAGE_W + IDX_W;
  localparam int DEPTH = POOL_PAGES * (2 ** IDX_W);
  localparam int VA_BITS = OFFSET_BITS + LEVEL_COUNT * IDX_W;
  localparam int VA_W = (VA_BITS > mlptw_pkg::VADDR_W) ? VA_BITS : mlptw_pkg::VADDR_W;
  localparam int LVL_W = $clog2(LEVEL_COUNT + 1);
  localparam int NEED_W = $clog2(LEVEL_COUNT + 2);
  localparam int CNT_W = $clog2(POOL_PAGES + 1);

  mlptw_pkg::walk_state_t state, state_next;

  logic [mlptw_pkg::CMD_W-1:0]    cmd;
  logic [VA_W-1:0]                va;
  logic [PAGE_W-1:0]              cur;
  logic [PAGE_W-1:0]              parent;
  logic [LVL_W-1:0]               lvl;
  logic [NEED_W-1:0]              need;
  logic                           make_root;
  logic                           root_present;
  logic [PAGE_W-1:0]              root_page;
  logic [POOL_PAGES-1:0]          used;
  logic [CNT_W-1:0]               free_cnt;
  logic [PAGE_W-1:0]              scan_p;
  logic [IDX_W-1:0]               clr_k;
  logic [mlptw_pkg::STATUS_W-1:0] res_status;
  logic [mlptw_pkg::PADDR_W-1:0]  res_pa;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [IDX_W-1:0]       idx;
  logic [OFFSET_BITS-1:0] off;
  logic                   hit;
  logic                   off_zero;

  assign off = va[OFFSET_BITS-1:0];
  assign off_zero = (off == '0);
  assign hit = rd_data[0] && ({1'b0, rd_data[ENTRY_W-1:1]} < (PAGE_W + 1)'(POOL_PAGES));

  always_comb begin
    idx = '0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      if (lvl == LVL_W'(l) || (l == LEVEL_COUNT - 1 && lvl == LVL_W'(LEVEL_COUNT))) begin
        idx = va[OFFSET_BITS + (LEVEL_COUNT - 1 - l) * IDX_W +: IDX_W];
      end
    end
  end

  assign rd_addr = {cur, idx};
  assign s_axis_tready = (state == mlptw_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // memory write control
  always_comb begin
    wr_en = 1'b0;
    wr_addr = {cur, idx};
    wr_data = '0;
    unique case (state)
      mlptw_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = {scan_p, clr_k};
      end
      mlptw_pkg::S_LINK: begin
        wr_en = !make_root;
        wr_data = {scan_p, 1'b1};
      end
      mlptw_pkg::S_FREE: begin
        wr_en = 1'b1;
        wr_addr = {parent, idx};
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mlptw_pkg::S_IDLE:
        if (s_axis_tvalid) state_next = mlptw_pkg::S_START;
      mlptw_pkg::S_START: begin
        if (cmd != mlptw_pkg::CMD_TRANSLATE && cmd != mlptw_pkg::CMD_ALLOCATE &&
            cmd != mlptw_pkg::CMD_DEALLOCATE) begin
          state_next = mlptw_pkg::S_RESP;
        end else if (cmd != mlptw_pkg::CMD_TRANSLATE && !off_zero) begin
          state_next = mlptw_pkg::S_RESP;
        end else if (!root_present) begin
          state_next = (cmd == mlptw_pkg::CMD_ALLOCATE) ? mlptw_pkg::S_CHECK
                                                         : mlptw_pkg::S_RESP;
        end else begin
          state_next = mlptw_pkg::S_READ;
        end
      end
      mlptw_pkg::S_READ: state_next = mlptw_pkg::S_READ_WAIT;
      mlptw_pkg::S_READ_WAIT:
        if (hit && lvl != LVL_W'(LEVEL_COUNT - 1)) state_next = mlptw_pkg::S_READ;
        else state_next = mlptw_pkg::S_DECIDE;
      mlptw_pkg::S_DECIDE: begin
        if (cmd == mlptw_pkg::CMD_ALLOCATE && lvl != LVL_W'(LEVEL_COUNT)) begin
          state_next = mlptw_pkg::S_CHECK;
        end else if (cmd == mlptw_pkg::CMD_DEALLOCATE && lvl == LVL_W'(LEVEL_COUNT)) begin
          state_next = mlptw_pkg::S_FREE;
        end else begin
          state_next = mlptw_pkg::S_RESP;
        end
      end
      mlptw_pkg::S_CHECK:
        if (free_cnt < CNT_W'(need)) state_next = mlptw_pkg::S_RESP;
        else state_next = mlptw_pkg::S_SCAN;
      mlptw_pkg::S_SCAN:
        if (!used[scan_p]) state_next = mlptw_pkg::S_CLEAR;
      mlptw_pkg::S_CLEAR:
        if (clr_k == '1) state_next = mlptw_pkg::S_LINK;
      mlptw_pkg::S_LINK:
        if (!make_root && lvl == LVL_W'(LEVEL_COUNT - 1)) state_next = mlptw_pkg::S_RESP;
        else state_next = mlptw_pkg::S_SCAN;
      mlptw_pkg::S_FREE: state_next = mlptw_pkg::S_RESP;
      mlptw_pkg::S_RESP:
        if (!m_axis_tvalid || m_axis_tready) state_next = mlptw_pkg::S_IDLE;
      default: state_next = mlptw_pkg::S_IDLE;
    endcase
  end

  // datapath and bookkeeping
  always_ff @(posedge clk) begin
    unique case (state)
      mlptw_pkg::S_IDLE:
        if (s_axis_tvalid) begin
          cmd <= s_axis_tdata[mlptw_pkg::CMD_W-1:0];
          va <= VA_W'(s_axis_tdata[31:mlptw_pkg::CMD_W]);
        end
      mlptw_pkg::S_START: begin
        res_pa <= '0;
        cur <= root_page;
        lvl <= '0;
        make_root <= !root_present;
        need <= NEED_W'(LEVEL_COUNT + 1);
        scan_p <= '0;
        if ((cmd == mlptw_pkg::CMD_ALLOCATE || cmd == mlptw_pkg::CMD_DEALLOCATE) &&
            !off_zero) begin
          res_status <= mlptw_pkg::ST_OFFSET;
        end else begin
          res_status <= mlptw_pkg::ST_NOT_MAPPED;
        end
      end
      mlptw_pkg::S_READ_WAIT:
        if (hit) begin
          parent <= cur;
          cur <= rd_data[ENTRY_W-1:1];
          lvl <= lvl + LVL_W'(1);
        end
      mlptw_pkg::S_DECIDE: begin
        need <= NEED_W'(LEVEL_COUNT) - NEED_W'(lvl);
        if (lvl == LVL_W'(LEVEL_COUNT)) begin
          if (cmd == mlptw_pkg::CMD_TRANSLATE) begin
            res_status <= mlptw_pkg::ST_DONE;
            res_pa <= mlptw_pkg::PADDR_W'({cur, off});
          end else if (cmd == mlptw_pkg::CMD_ALLOCATE) begin
            res_status <= mlptw_pkg::ST_MAPPED;
            res_pa <= mlptw_pkg::PADDR_W'({cur, {OFFSET_BITS{1'b0}}});
          end
        end
      end
      mlptw_pkg::S_CHECK:
        if (free_cnt < CNT_W'(need)) res_status <= mlptw_pkg::ST_EXHAUSTED;
      mlptw_pkg::S_SCAN: begin
        clr_k <= '0;
        if (used[scan_p]) scan_p <= scan_p + PAGE_W'(1);
      end
      mlptw_pkg::S_CLEAR: clr_k <= clr_k + IDX_W'(1);
      mlptw_pkg::S_LINK: begin
        cur <= scan_p;
        scan_p <= '0;
        make_root <= 1'b0;
        if (!make_root) begin
          lvl <= lvl + LVL_W'(1);
          res_status <= mlptw_pkg::ST_DONE;
          res_pa <= mlptw_pkg::PADDR_W'({scan_p, {OFFSET_BITS{1'b0}}});
        end
      end
      mlptw_pkg::S_FREE: begin
        res_status <= mlptw_pkg::ST_DONE;
        res_pa <= mlptw_pkg::PADDR_W'({cur, {OFFSET_BITS{1'b0}}});
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlptw_pkg::S_IDLE;
      root_present <= 1'b0;
      root_page <= '0;
      used <= '0;
      free_cnt <= CNT_W'(POOL_PAGES);
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
    end else begin
      state <= state_next;
      if (state == mlptw_pkg::S_SCAN && !used[scan_p]) begin
        used[scan_p] <= 1'b1;
        free_cnt <= free_cnt - CNT_W'(1);
      end
      if (state == mlptw_pkg::S_LINK && make_root) begin
        root_page <= scan_p;
        root_present <= 1'b1;
      end
      if (state == mlptw_pkg::S_FREE) begin
        used[cur] <= 1'b0;
        free_cnt <= free_cnt + CNT_W'(1);
      end
      if (state == mlptw_pkg::S_RESP && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {3'b000, res_pa, res_status};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule
